// ===== design/uvs_pkg.sv =====
// Package for the UV sphere mesh generator: widths, codes, command and status
// structs and the CORDIC arctangent table.
// No dependencies; every other design file but uvs_div imports it.
package uvs_pkg;

    localparam int CFG_W        = 9;
    localparam int CFG_ADDR_W   = 1;
    localparam int IDX_W        = 10;
    localparam int ANG_W        = 32;
    localparam int DVD_W        = IDX_W + ANG_W;
    localparam int TEX_W        = 17;
    localparam int VIDX_W       = 17;
    localparam int POS_W        = 16;
    localparam int KIND_W       = 2;
    localparam int CORD_W       = 34;
    localparam int CORD_STEPS   = 24;
    localparam int STEP_W       = 5;
    localparam int CORD_GAIN    = 652032874;
    localparam int IN_W         = 8;
    localparam int OUT_W        = 136;

    localparam int DEF_SECTORS     = 32;
    localparam int DEF_STACKS      = 16;
    localparam int MIN_SECTORS     = 3;
    localparam int MIN_STACKS      = 2;
    localparam int DEF_MAX_SECTORS = 256;
    localparam int DEF_MAX_STACKS  = 256;
    localparam int DEF_FRAC_BITS   = 14;

    localparam int TEX_ONE       = 65536;
    localparam int STACK_SH      = ANG_W - 1;
    localparam int SECTOR_SH     = ANG_W;
    localparam int TEX_SH        = TEX_W;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;

    localparam logic [CFG_ADDR_W-1:0] REG_SECTORS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_STACKS  = 1'b1;

    typedef enum logic [1:0] {
        PH_VERTEX,
        PH_TRIANGLE,
        PH_DONE
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VERTEX,
        KIND_TRIANGLE,
        KIND_DONE
    } kind_t;

    typedef enum logic [1:0] {
        DIV_STACK,
        DIV_SECTOR,
        DIV_TEXS,
        DIV_TEXT
    } div_sel_t;

    typedef enum logic {
        ROT_STACK,
        ROT_SECTOR
    } rot_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ROW_DIV,
        ST_ROW_DIVW,
        ST_ROW_ROT,
        ST_ROW_ROTW,
        ST_COL_DIV,
        ST_COL_DIVW,
        ST_COL_ROT,
        ST_COL_ROTW,
        ST_TS_DIV,
        ST_TS_DIVW,
        ST_TT_DIV,
        ST_TT_DIVW,
        ST_VTX_OUT,
        ST_VSETTLE,
        ST_TRI,
        ST_TSETTLE,
        ST_TRI_OUT,
        ST_DONE_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic     take;
        logic     div_start;
        div_sel_t div_sel;
        logic     rot_start;
        rot_sel_t rot_sel;
        logic     cap_ring;
        logic     cap_prod;
        logic     cap_texs;
        logic     cap_text;
        logic     put_vtx;
        logic     tri_emit;
        logic     settle;
        logic     put_tri;
        logic     put_done;
    } ctrl_cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   col_zero;
        logic   div_done;
        logic   rot_done;
        logic   out_free;
        logic   settle_busy;
    } dp_status_t;

    // Arctangent of 2^-k as a fraction of a full turn scaled by 2^32.
    function automatic logic [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [ANG_W-1:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/uv_sphere_mesh_generator.sv =====
// UV sphere mesh generator: one mesh element per request beat.
// A vertex makes three or four passes of the one-bit-per-cycle divider and one or two
// 24-step CORDICs, the larger numbers at the first column of a row.
// After a triangle is stepped, empty halves are skipped before it is loaded for output.
// One request is worked on at a time; a result waits in the output register.
// Synchronous active-low reset: counts 32 and 16, mesh in the done phase, no result pending.
module uv_sphere_mesh_generator #(
    parameter int MAX_SECTORS = uvs_pkg::DEF_MAX_SECTORS,
    parameter int MAX_STACKS  = uvs_pkg::DEF_MAX_STACKS,
    parameter int FRAC_BITS   = uvs_pkg::DEF_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [uvs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [uvs_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // bit 0: restart; bits 7:1 zero
    input  logic [uvs_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pos_x, pos_y, pos_z, tex_s, tex_t, corner_a, corner_b, corner_c; zero fill
    output logic [uvs_pkg::OUT_W-1:0]       m_tdata,
    // item_kind
    output logic [uvs_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast
);
    import uvs_pkg::*;

    localparam int PACK_W = 3 * POS_W + 2 * TEX_W + 3 * VIDX_W;

    ctrl_cmd_t          cmd;
    dp_status_t         sts;
    kind_t              out_kind;
    logic [POS_W-1:0]   pos_x, pos_y, pos_z;
    logic [TEX_W-1:0]   tex_s, tex_t;
    logic [VIDX_W-1:0]  corner_a, corner_b, corner_c;

    uvs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    uvs_dp #(
        .MAX_SECTORS (MAX_SECTORS),
        .MAX_STACKS  (MAX_STACKS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_restart    (s_tdata[0]),
        .cmd          (cmd),
        .sts          (sts),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .out_kind     (out_kind),
        .out_pos_x    (pos_x),
        .out_pos_y    (pos_y),
        .out_pos_z    (pos_z),
        .out_tex_s    (tex_s),
        .out_tex_t    (tex_t),
        .out_corner_a (corner_a),
        .out_corner_b (corner_b),
        .out_corner_c (corner_c),
        .out_last     (m_tlast)
    );

    assign m_tdata = {{(OUT_W-PACK_W){1'b0}}, corner_c, corner_b, corner_a,
                      tex_t, tex_s, pos_z, pos_y, pos_x};
    assign m_tuser = out_kind;

endmodule

// ===== design/uvs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module uvs_div #(
    parameter int DVD_W = 42,
    parameter int DEN_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/uvs_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle in Q30.
// Depends on uvs_pkg for widths, gain and the arctangent table.
module uvs_cordic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [uvs_pkg::ANG_W-1:0]           angle,
    output logic                                done,
    output logic signed [uvs_pkg::CORD_W-1:0]   cos_out,
    output logic signed [uvs_pkg::CORD_W-1:0]   sin_out
);
    import uvs_pkg::*;

    logic signed [CORD_W-1:0] x_reg, x_next;
    logic signed [CORD_W-1:0] y_reg, y_next;
    logic signed [CORD_W-1:0] z_reg, z_next;
    logic [STEP_W-1:0]        k_reg, k_next;
    logic                     flip_reg, flip_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [ANG_W-1:0]         a_off, a_rot;
    logic                     rot_flip;
    logic signed [CORD_W-1:0] dx, dy, at;

    // Angles in the left half plane are turned by half a turn and negated at the end.
    assign a_off    = angle - QUARTER_TURN;
    assign rot_flip = ~a_off[ANG_W-1];
    assign a_rot    = rot_flip ? (angle ^ HALF_TURN) : angle;

    assign dx = y_reg >>> k_reg;
    assign dy = x_reg >>> k_reg;
    assign at = signed'({{(CORD_W-ANG_W){1'b0}}, atan_turn(k_reg)});

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        k_next    = k_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = CORD_W'(CORD_GAIN);
            y_next    = '0;
            z_next    = CORD_W'(signed'(a_rot));
            k_next    = '0;
            flip_next = rot_flip;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[CORD_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            k_next = k_reg + STEP_W'(1);
            if (k_reg == STEP_W'(CORD_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

// ===== design/uvs_dp.sv =====
// Datapath of the mesh generator: configuration, mesh counters, the shared
// divider and CORDIC, position products and the output register.
// Depends on uvs_pkg, uvs_div and uvs_cordic.
module uvs_dp #(
    parameter int MAX_SECTORS = uvs_pkg::DEF_MAX_SECTORS,
    parameter int MAX_STACKS  = uvs_pkg::DEF_MAX_STACKS,
    parameter int FRAC_BITS   = uvs_pkg::DEF_FRAC_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [uvs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [uvs_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_restart,
    input  uvs_pkg::ctrl_cmd_t               cmd,
    output uvs_pkg::dp_status_t              sts,
    input  logic                             m_tready,
    output logic                             out_valid,
    output uvs_pkg::kind_t                   out_kind,
    output logic [uvs_pkg::POS_W-1:0]        out_pos_x,
    output logic [uvs_pkg::POS_W-1:0]        out_pos_y,
    output logic [uvs_pkg::POS_W-1:0]        out_pos_z,
    output logic [uvs_pkg::TEX_W-1:0]        out_tex_s,
    output logic [uvs_pkg::TEX_W-1:0]        out_tex_t,
    output logic [uvs_pkg::VIDX_W-1:0]       out_corner_a,
    output logic [uvs_pkg::VIDX_W-1:0]       out_corner_b,
    output logic [uvs_pkg::VIDX_W-1:0]       out_corner_c,
    output logic                             out_last
);
    import uvs_pkg::*;

    localparam int    FW        = FRAC_BITS + 2;
    localparam int    SH        = 30 - FRAC_BITS;
    localparam int    RND       = (1 << SH) >> 1;
    localparam int    PW        = FW + CORD_W;
    localparam longint ONE      = 64'sd1 << FRAC_BITS;
    localparam longint PROD_RND = 64'sd1 << 29;

    // Q30 to Q(FRAC_BITS): round half up, floor shift, clamp to plus or minus one.
    function automatic logic signed [FW-1:0] to_frac(input logic signed [CORD_W-1:0] v);
        logic signed [CORD_W:0] t;
        logic signed [CORD_W:0] one;
        t   = ((CORD_W+1)'(v) + (CORD_W+1)'(RND)) >>> SH;
        one = (CORD_W+1)'(ONE);
        if (t > one) begin
            return FW'(one);
        end else if (t < -one) begin
            return FW'(-one);
        end
        return FW'(t);
    endfunction

    function automatic logic signed [FW-1:0] round_prod(input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        logic signed [PW:0] one;
        t   = ((PW+1)'(p) + (PW+1)'(PROD_RND)) >>> 30;
        one = (PW+1)'(ONE);
        if (t > one) begin
            return FW'(one);
        end else if (t < -one) begin
            return FW'(-one);
        end
        return FW'(t);
    endfunction

    // The divider gives floor(n * 2^17 / d); halving after adding one rounds it.
    function automatic logic [TEX_W-1:0] to_tex(input logic [DVD_W-1:0] q);
        logic [DVD_W:0] r;
        r = ((DVD_W+1)'(q) + (DVD_W+1)'(1)) >> 1;
        if (r > (DVD_W+1)'(TEX_ONE)) begin
            return TEX_W'(TEX_ONE);
        end
        return r[TEX_W-1:0];
    endfunction

    logic [CFG_W-1:0]        sector_reg, sector_next;
    logic [CFG_W-1:0]        stack_reg, stack_next;
    phase_t                  phase_reg, phase_next;
    logic [IDX_W-1:0]        row_reg, row_next;
    logic [IDX_W-1:0]        col_reg, col_next;
    logic [VIDX_W-1:0]       rbi_reg, rbi_next;
    logic                    half_reg, half_next;
    logic signed [FW-1:0]    ring_reg, height_reg;
    logic signed [PW-1:0]    prod_s_reg, prod_c_reg;
    logic [TEX_W-1:0]        tex_s_reg, tex_t_reg;
    logic [VIDX_W-1:0]       tri_a_reg, tri_b_reg, tri_c_reg;
    logic                    out_valid_reg, out_valid_next;
    kind_t                   out_kind_reg;
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg, pos_z_reg;
    logic [TEX_W-1:0]        otex_s_reg, otex_t_reg;
    logic [VIDX_W-1:0]       ca_reg, cb_reg, cc_reg;
    logic                    last_reg;

    logic [CFG_W-1:0]        ns, nt;
    logic [IDX_W-1:0]        ns_i, nt_i;
    logic [VIDX_W-1:0]       rbi_adv;
    logic [IDX_W:0]          col_inc, row_inc;
    logic                    tri_ok, settle_busy, out_free;
    logic [IDX_W-1:0]        ts_row, ts_col;
    logic [VIDX_W-1:0]       ts_rbi;
    logic                    ts_half;
    logic [VIDX_W-1:0]       k1, k2;
    logic [DVD_W-1:0]        div_dvd;
    logic [CFG_W-1:0]        div_den;
    logic                    div_done;
    logic [DVD_W-1:0]        quo;
    logic [ANG_W-1:0]        rot_angle;
    logic                    rot_done;
    logic signed [CORD_W-1:0] cor_c, cor_s;

    // Effective counts, clamped to the supported range.
    always_comb begin
        ns = (int'(sector_reg) > MAX_SECTORS) ? CFG_W'(MAX_SECTORS) : sector_reg;
        if (ns < CFG_W'(MIN_SECTORS)) begin
            ns = CFG_W'(MIN_SECTORS);
        end
        nt = (int'(stack_reg) > MAX_STACKS) ? CFG_W'(MAX_STACKS) : stack_reg;
        if (nt < CFG_W'(MIN_STACKS)) begin
            nt = CFG_W'(MIN_STACKS);
        end
    end

    assign ns_i    = IDX_W'(ns);
    assign nt_i    = IDX_W'(nt);
    assign rbi_adv = rbi_reg + VIDX_W'(ns) + VIDX_W'(1);
    assign col_inc = (IDX_W+1)'(col_reg) + (IDX_W+1)'(1);
    assign row_inc = (IDX_W+1)'(row_reg) + (IDX_W+1)'(1);

    // Row zero has no upper triangle and the last row no lower one.
    assign tri_ok      = half_reg ? (row_reg != nt_i - IDX_W'(1)) : (row_reg != '0);
    assign settle_busy = (phase_reg == PH_TRIANGLE) && (row_reg < nt_i)
                         && ((col_reg >= ns_i) || !tri_ok);
    assign out_free    = !out_valid_reg || m_tready;

    // One step through the triangle list.
    always_comb begin
        ts_half = ~half_reg;
        ts_col  = col_reg;
        ts_row  = row_reg;
        ts_rbi  = rbi_reg;
        if (half_reg) begin
            if (col_inc >= (IDX_W+1)'(ns_i)) begin
                ts_col = '0;
                ts_row = row_inc[IDX_W-1:0];
                ts_rbi = rbi_adv;
            end else begin
                ts_col = col_inc[IDX_W-1:0];
            end
        end
    end

    assign k1 = rbi_reg + VIDX_W'(col_reg);
    assign k2 = k1 + VIDX_W'(ns) + VIDX_W'(1);

    always_comb begin
        case (cmd.div_sel)
            DIV_STACK: begin
                div_dvd = DVD_W'(row_reg) << STACK_SH;
                div_den = nt;
            end
            DIV_SECTOR: begin
                div_dvd = DVD_W'(col_reg) << SECTOR_SH;
                div_den = ns;
            end
            DIV_TEXS: begin
                div_dvd = DVD_W'(col_reg) << TEX_SH;
                div_den = ns;
            end
            default: begin
                div_dvd = DVD_W'(row_reg) << TEX_SH;
                div_den = nt;
            end
        endcase
    end

    assign rot_angle = (cmd.rot_sel == ROT_STACK) ? (QUARTER_TURN - quo[ANG_W-1:0])
                                                  : quo[ANG_W-1:0];

    uvs_div #(
        .DVD_W (DVD_W),
        .DEN_W (CFG_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (quo)
    );

    uvs_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.rot_start),
        .angle   (rot_angle),
        .done    (rot_done),
        .cos_out (cor_c),
        .sin_out (cor_s)
    );

    always_comb begin
        sector_next    = sector_reg;
        stack_next     = stack_reg;
        phase_next     = phase_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rbi_next       = rbi_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we) begin
            case (cfg_addr)
                REG_SECTORS: sector_next = cfg_wdata;
                REG_STACKS:  stack_next  = cfg_wdata;
                default:     sector_next = sector_reg;
            endcase
        end

        if (cmd.take && s_restart) begin
            phase_next = PH_VERTEX;
            row_next   = '0;
            col_next   = '0;
            rbi_next   = '0;
            half_next  = 1'b0;
        end

        if (cmd.put_vtx) begin
            if (col_inc > (IDX_W+1)'(ns_i)) begin
                col_next = '0;
                if (row_inc > (IDX_W+1)'(nt_i)) begin
                    phase_next = PH_TRIANGLE;
                    row_next   = '0;
                    rbi_next   = '0;
                    half_next  = 1'b0;
                end else begin
                    row_next = row_inc[IDX_W-1:0];
                end
            end else begin
                col_next = col_inc[IDX_W-1:0];
            end
        end

        if (cmd.tri_emit) begin
            half_next = ts_half;
            col_next  = ts_col;
            row_next  = ts_row;
            rbi_next  = ts_rbi;
        end

        if (cmd.settle) begin
            if (settle_busy) begin
                if (col_reg >= ns_i) begin
                    col_next  = '0;
                    half_next = 1'b0;
                    row_next  = row_inc[IDX_W-1:0];
                    rbi_next  = rbi_adv;
                end else begin
                    half_next = ts_half;
                    col_next  = ts_col;
                    row_next  = ts_row;
                    rbi_next  = ts_rbi;
                end
            end else if ((phase_reg == PH_TRIANGLE) && (row_reg >= nt_i)) begin
                phase_next = PH_DONE;
            end
        end

        if (cmd.put_vtx || cmd.put_tri || cmd.put_done) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_reg    <= CFG_W'(DEF_SECTORS);
            stack_reg     <= CFG_W'(DEF_STACKS);
            phase_reg     <= PH_DONE;
            row_reg       <= '0;
            col_reg       <= '0;
            rbi_reg       <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sector_reg    <= sector_next;
            stack_reg     <= stack_next;
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            rbi_reg       <= rbi_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_ring) begin
            ring_reg   <= to_frac(cor_c);
            height_reg <= to_frac(cor_s);
        end
        if (cmd.cap_prod) begin
            prod_s_reg <= ring_reg * cor_s;
            prod_c_reg <= ring_reg * cor_c;
        end
        if (cmd.cap_texs) begin
            tex_s_reg <= to_tex(quo);
        end
        if (cmd.cap_text) begin
            tex_t_reg <= to_tex(quo);
        end
        if (cmd.tri_emit) begin
            tri_b_reg <= k2;
            if (!half_reg) begin
                tri_a_reg <= k1;
                tri_c_reg <= k1 + VIDX_W'(1);
            end else begin
                tri_a_reg <= k1 + VIDX_W'(1);
                tri_c_reg <= k2 + VIDX_W'(1);
            end
        end
        if (cmd.put_vtx) begin
            out_kind_reg <= KIND_VERTEX;
            pos_x_reg    <= POS_W'(round_prod(prod_s_reg));
            pos_y_reg    <= POS_W'(height_reg);
            pos_z_reg    <= POS_W'(round_prod(prod_c_reg));
            otex_s_reg   <= tex_s_reg;
            otex_t_reg   <= tex_t_reg;
            ca_reg       <= '0;
            cb_reg       <= '0;
            cc_reg       <= '0;
            last_reg     <= 1'b0;
        end else if (cmd.put_tri) begin
            out_kind_reg <= KIND_TRIANGLE;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            otex_s_reg   <= '0;
            otex_t_reg   <= '0;
            ca_reg       <= tri_a_reg;
            cb_reg       <= tri_b_reg;
            cc_reg       <= tri_c_reg;
            last_reg     <= (phase_reg == PH_DONE);
        end else if (cmd.put_done) begin
            out_kind_reg <= KIND_DONE;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            otex_s_reg   <= '0;
            otex_t_reg   <= '0;
            ca_reg       <= '0;
            cb_reg       <= '0;
            cc_reg       <= '0;
            last_reg     <= 1'b0;
        end
    end

    assign sts.phase       = phase_reg;
    assign sts.col_zero    = (col_reg == '0);
    assign sts.div_done    = div_done;
    assign sts.rot_done    = rot_done;
    assign sts.out_free    = out_free;
    assign sts.settle_busy = settle_busy;

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_pos_x    = pos_x_reg;
    assign out_pos_y    = pos_y_reg;
    assign out_pos_z    = pos_z_reg;
    assign out_tex_s    = otex_s_reg;
    assign out_tex_t    = otex_t_reg;
    assign out_corner_a = ca_reg;
    assign out_corner_b = cb_reg;
    assign out_corner_c = cc_reg;
    assign out_last     = last_reg;

endmodule

// ===== design/uvs_ctrl.sv =====
// Controller of the mesh generator: sequences divisions, rotations, triangle
// steps and output loads for one request beat at a time.
// Depends on uvs_pkg.
module uvs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  uvs_pkg::dp_status_t   sts,
    output uvs_pkg::ctrl_cmd_t    cmd
);
    import uvs_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                case (sts.phase)
                    PH_VERTEX:   state_next = sts.col_zero ? ST_ROW_DIV : ST_COL_DIV;
                    PH_TRIANGLE: state_next = ST_TRI;
                    default:     state_next = ST_DONE_OUT;
                endcase
            end
            ST_ROW_DIV:  state_next = ST_ROW_DIVW;
            ST_ROW_DIVW: if (sts.div_done) state_next = ST_ROW_ROT;
            ST_ROW_ROT:  state_next = ST_ROW_ROTW;
            ST_ROW_ROTW: if (sts.rot_done) state_next = ST_COL_DIV;
            ST_COL_DIV:  state_next = ST_COL_DIVW;
            ST_COL_DIVW: if (sts.div_done) state_next = ST_COL_ROT;
            ST_COL_ROT:  state_next = ST_COL_ROTW;
            ST_COL_ROTW: if (sts.rot_done) state_next = ST_TS_DIV;
            ST_TS_DIV:   state_next = ST_TS_DIVW;
            ST_TS_DIVW:  if (sts.div_done) state_next = ST_TT_DIV;
            ST_TT_DIV:   state_next = ST_TT_DIVW;
            ST_TT_DIVW:  if (sts.div_done) state_next = ST_VTX_OUT;
            ST_VTX_OUT:  if (sts.out_free) state_next = ST_VSETTLE;
            ST_VSETTLE:  if (!sts.settle_busy) state_next = ST_IDLE;
            ST_TRI:      state_next = ST_TSETTLE;
            ST_TSETTLE:  if (!sts.settle_busy) state_next = ST_TRI_OUT;
            ST_TRI_OUT:  if (sts.out_free) state_next = ST_IDLE;
            ST_DONE_OUT: if (sts.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_ROW_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_STACK;
            end
            ST_ROW_ROT: begin
                cmd.rot_start = 1'b1;
                cmd.rot_sel   = ROT_STACK;
            end
            ST_ROW_ROTW: cmd.cap_ring = sts.rot_done;
            ST_COL_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SECTOR;
            end
            ST_COL_ROT: begin
                cmd.rot_start = 1'b1;
                cmd.rot_sel   = ROT_SECTOR;
            end
            ST_COL_ROTW: cmd.cap_prod = sts.rot_done;
            ST_TS_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TEXS;
            end
            ST_TS_DIVW:  cmd.cap_texs = sts.div_done;
            ST_TT_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TEXT;
            end
            ST_TT_DIVW:  cmd.cap_text = sts.div_done;
            ST_VTX_OUT:  cmd.put_vtx  = sts.out_free;
            ST_VSETTLE:  cmd.settle   = 1'b1;
            ST_TRI:      cmd.tri_emit = 1'b1;
            ST_TSETTLE:  cmd.settle   = 1'b1;
            ST_TRI_OUT:  cmd.put_tri  = sts.out_free;
            ST_DONE_OUT: cmd.put_done = sts.out_free;
            default:     cmd          = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== test/tb_uv_sphere_mesh_generator.sv =====
// Testbench for uv_sphere_mesh_generator: drives advance/restart beats and checks
// every vertex, triangle and done beat against an in-bench sphere predictor.
// Depends on uvs_pkg and the uv_sphere_mesh_generator RTL.
`timescale 1ns / 1ps

module tb_uv_sphere_mesh_generator;
    import uvs_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;

    typedef struct {
        kind_t       kind;
        logic [15:0] px, py, pz;
        logic [16:0] ts, tt, ca, cb, cc;
        logic        last;
    } element_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic m_tlast;

    uv_sphere_mesh_generator dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state.
    logic [8:0]  sectors_reg, stacks_reg;
    phase_t      mesh_phase;
    int unsigned cur_row, cur_col, base_idx, half;
    longint      ring_q, height_q;

    element_t pending_elems[$];
    int       n_errors = 0;
    int       n_checked = 0;
    int       n_vertices = 0, n_triangles = 0, n_dones = 0;
    longint   cycle_count = 0;
    bit       calm = 1'b0;

    longint atan_tab[CORD_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    function automatic longint clamp_unit(longint v);
        longint one = longint'(1) << DEF_FRAC_BITS;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function automatic void sin_cos(input bit [31:0] ang, output longint c, output longint s);
        bit [31:0] a = ang;
        bit [31:0] off;
        bit        flip = 1'b0;
        longint    x = CORD_GAIN, y = 0, z, dx, dy;
        off = a - QUARTER_TURN;
        if (off < HALF_TURN) begin
            a = a - HALF_TURN;
            flip = 1'b1;
        end
        z = longint'(signed'(a));
        for (int k = 0; k < CORD_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[k];
            end else begin
                x += dx; y -= dy; z += atan_tab[k];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic int unsigned live_sectors();
        return (sectors_reg < 3) ? 3 : ((sectors_reg > DEF_MAX_SECTORS) ? DEF_MAX_SECTORS : sectors_reg);
    endfunction

    function automatic int unsigned live_stacks();
        return (stacks_reg < 2) ? 2 : ((stacks_reg > DEF_MAX_STACKS) ? DEF_MAX_STACKS : stacks_reg);
    endfunction

    function automatic logic [16:0] tex_ratio(longint unsigned num, longint unsigned den);
        longint unsigned r = ((num << 17) + den) / (den * 2);
        return (r > TEX_ONE) ? 17'(TEX_ONE) : 17'(r);
    endfunction

    function automatic bit half_exists(int unsigned nt);
        return (half == 0) ? (cur_row != 0) : (cur_row != nt - 1);
    endfunction

    function automatic void next_half(int unsigned ns);
        half ^= 1;
        if (half == 0) begin
            cur_col++;
            if (cur_col >= ns) begin
                cur_col = 0;
                cur_row++;
                base_idx += ns + 1;
            end
        end
    endfunction

    // Skips triangle slots that do not exist; ends the mesh past the last row.
    function automatic void skip_empty_halves();
        int unsigned ns = live_sectors();
        int unsigned nt = live_stacks();
        while (cur_row < nt && (cur_col >= ns || !half_exists(nt))) begin
            if (cur_col >= ns) begin
                cur_col = 0;
                half = 0;
                cur_row++;
                base_idx += ns + 1;
            end else begin
                next_half(ns);
            end
        end
        if (cur_row >= nt) mesh_phase = PH_DONE;
    endfunction

    function automatic element_t predict_element(bit restart);
        element_t    e;
        int unsigned ns = live_sectors();
        int unsigned nt = live_stacks();
        longint      c, s, ang;
        bit [31:0]   k1, k2;
        e = '{kind: KIND_DONE, default: '0};
        if (restart) begin
            mesh_phase = PH_VERTEX;
            cur_row = 0; cur_col = 0; base_idx = 0; half = 0;
        end
        if (mesh_phase == PH_VERTEX) begin
            if (cur_col == 0) begin
                ang = longint'(QUARTER_TURN) - ((longint'(cur_row) << 31) / nt);
                sin_cos(32'(ang), c, s);
                ring_q = clamp_unit((c + (longint'(1) << 15)) >>> 16);
                height_q = clamp_unit((s + (longint'(1) << 15)) >>> 16);
            end
            sin_cos(32'((longint'(cur_col) << 32) / ns), c, s);
            e.kind = KIND_VERTEX;
            e.px = 16'(clamp_unit((ring_q * s + (longint'(1) << 29)) >>> 30));
            e.py = 16'(height_q);
            e.pz = 16'(clamp_unit((ring_q * c + (longint'(1) << 29)) >>> 30));
            e.ts = tex_ratio(cur_col, ns);
            e.tt = tex_ratio(cur_row, nt);
            cur_col++;
            if (cur_col > live_sectors()) begin
                cur_col = 0;
                cur_row++;
                if (cur_row > live_stacks()) begin
                    mesh_phase = PH_TRIANGLE;
                    cur_row = 0; base_idx = 0; half = 0;
                    skip_empty_halves();
                end
            end
        end else if (mesh_phase == PH_TRIANGLE) begin
            k1 = base_idx + cur_col;
            k2 = k1 + ns + 1;
            e.kind = KIND_TRIANGLE;
            if (half == 0) begin
                e.ca = 17'(k1); e.cb = 17'(k2); e.cc = 17'(k1 + 1);
            end else begin
                e.ca = 17'(k1 + 1); e.cb = 17'(k2); e.cc = 17'(k2 + 1);
            end
            next_half(ns);
            skip_empty_halves();
            e.last = (mesh_phase == PH_DONE);
        end
        return e;
    endfunction

    // Sends one request beat; the element it causes is predicted on acceptance.
    task automatic send_request(bit restart);
        int gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-1){1'b0}}, restart};
        do @(posedge aclk); while (!s_tready);
        pending_elems.push_back(predict_element(restart));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_elems.size() == 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        drain();
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_SECTORS) sectors_reg = val; else stacks_reg = val;
    endtask

    task automatic run_mesh(int advances);
        send_request(1'b1);
        repeat (advances) send_request(1'b0);
    endtask

    task automatic test_done_after_reset();
        repeat (3) send_request(1'b0);
    endtask

    task automatic test_smallest_mesh();
        write_reg(REG_SECTORS, 9'd3);
        write_reg(REG_STACKS, 9'd2);
        run_mesh(19);
    endtask

    task automatic test_clamped_counts();
        write_reg(REG_SECTORS, 9'd0);
        write_reg(REG_STACKS, 9'd1);
        run_mesh(8);
        write_reg(REG_SECTORS, 9'd511);
        write_reg(REG_STACKS, 9'd511);
        run_mesh(4);
    endtask

    // A full row at the widest setting reaches the texture coordinate of one.
    task automatic test_widest_row();
        write_reg(REG_SECTORS, 9'd256);
        write_reg(REG_STACKS, 9'd256);
        calm = 1'b1;
        run_mesh(258);
        calm = 1'b0;
    endtask

    task automatic test_counts_changed_mid_mesh();
        write_reg(REG_SECTORS, 9'd6);
        write_reg(REG_STACKS, 9'd4);
        run_mesh(9);
        write_reg(REG_SECTORS, 9'd3);
        repeat (12) send_request(1'b0);
        write_reg(REG_STACKS, 9'd2);
        repeat (14) send_request(1'b0);
    endtask

    task automatic test_random_meshes();
        int sent = 0;
        int len;
        while (sent < 270) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_SECTORS, CFG_W'($urandom_range(0, 7)));
                write_reg(REG_STACKS, CFG_W'($urandom_range(0, 5)));
            end
            // Mostly whole meshes with a few done beats; sometimes cut short.
            len = live_sectors() * live_stacks() * 3 + 8;
            if ($urandom_range(0, 4) == 0) len = $urandom_range(1, len);
            send_request(1'b1);
            for (int i = 0; i < len; i++) send_request($urandom_range(0, 30) == 0);
            sent += len + 1;
        end
        calm = 1'b0;
    endtask

    // Result side: random stall per beat, with calm stretches.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            stall_left <= calm ? 0 : $urandom_range(0, 19);
            m_tready <= calm;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        element_t e;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_elems.size() == 0) begin
                $error("element beat with none expected");
                n_errors++;
            end else begin
                e = pending_elems.pop_front();
                n_checked++;
                case (e.kind)
                    KIND_VERTEX:   n_vertices++;
                    KIND_TRIANGLE: n_triangles++;
                    default:       n_dones++;
                endcase
                if (m_tuser !== e.kind) begin
                    $error("item_kind: expected %0d, got %0d", e.kind, m_tuser); n_errors++;
                end
                if (m_tdata[15:0] !== e.px) begin
                    $error("pos_x: expected %0h, got %0h", e.px, m_tdata[15:0]); n_errors++;
                end
                if (m_tdata[31:16] !== e.py) begin
                    $error("pos_y: expected %0h, got %0h", e.py, m_tdata[31:16]); n_errors++;
                end
                if (m_tdata[47:32] !== e.pz) begin
                    $error("pos_z: expected %0h, got %0h", e.pz, m_tdata[47:32]); n_errors++;
                end
                if (m_tdata[64:48] !== e.ts) begin
                    $error("tex_s: expected %0d, got %0d", e.ts, m_tdata[64:48]); n_errors++;
                end
                if (m_tdata[81:65] !== e.tt) begin
                    $error("tex_t: expected %0d, got %0d", e.tt, m_tdata[81:65]); n_errors++;
                end
                if (m_tdata[98:82] !== e.ca) begin
                    $error("corner_a: expected %0d, got %0d", e.ca, m_tdata[98:82]); n_errors++;
                end
                if (m_tdata[115:99] !== e.cb) begin
                    $error("corner_b: expected %0d, got %0d", e.cb, m_tdata[115:99]); n_errors++;
                end
                if (m_tdata[132:116] !== e.cc) begin
                    $error("corner_c: expected %0d, got %0d", e.cc, m_tdata[132:116]);
                    n_errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_item: expected %0b, got %0b", e.last, m_tlast); n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        sectors_reg = 9'(DEF_SECTORS);
        stacks_reg  = 9'(DEF_STACKS);
        mesh_phase = PH_DONE;
        cur_row = 0; cur_col = 0; base_idx = 0; half = 0;
        ring_q = 0; height_q = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_done_after_reset();
        test_smallest_mesh();
        test_clamped_counts();
        test_widest_row();
        test_counts_changed_mid_mesh();
        test_random_meshes();
        drain();
        repeat (300) @(posedge aclk);
        if (pending_elems.size() != 0) begin
            $error("%0d elements never arrived", pending_elems.size());
            n_errors++;
        end
        $display("Checked %0d beats: %0d vertices, %0d triangles, %0d done beats,",
                 n_checked, n_vertices, n_triangles, n_dones);
        $display("over clamped, widest and mid-mesh count changes and random meshes.");
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
